// ===== sv/midi_track_event_parser_unit_defines.svh =====
// assertion macros for the track parser
`ifndef MIDI_TRACK_EVENT_PARSER_UNIT_DEFINES_SVH
`define MIDI_TRACK_EVENT_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define MTEP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("track parser check failed");

// next-cycle implication, checked while out of reset
`define MTEP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("track parser check failed");

`endif

// ===== sv/mtep_pkg.sv =====
`default_nettype none

package mtep_pkg;

	localparam int TICK_BITS = 28;
	localparam int VLV_BITS = 28;
	localparam int LEN_BITS = 32;
	localparam logic [TICK_BITS:0] TICK_MAX = {1'b0, {TICK_BITS{1'b1}}};

	localparam logic [7:0] META_TEMPO = 8'h51;
	localparam logic [7:0] META_EOT = 8'h2F;
	localparam logic [7:0] SYSEX_START = 8'hF0;
	localparam logic [7:0] SYSEX_ESC = 8'hF7;
	localparam logic [7:0] META_PREFIX = 8'hFF;
	localparam logic [2:0] VLV_MAX_BYTES = 3'd4;
	localparam logic [VLV_BITS-1:0] TEMPO_LEN = 28'd3;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'd0,
		PH_HDR   = 4'd1,
		PH_DELTA = 4'd2,
		PH_EVENT = 4'd3,
		PH_DATA1 = 4'd4,
		PH_DATA2 = 4'd5,
		PH_MTYPE = 4'd6,
		PH_MLEN  = 4'd7,
		PH_SLEN  = 4'd8,
		PH_SKIP  = 4'd9,
		PH_TAIL  = 4'd10
	} phase_t;

	typedef enum logic [1:0] {
		KIND_CHAN  = 2'd0,
		KIND_TEMPO = 2'd1,
		KIND_DONE  = 2'd2,
		KIND_ERROR = 2'd3
	} kind_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] m;
		unique case (idx)
			2'd0: m = 8'h4D;
			2'd1: m = 8'h54;
			2'd2: m = 8'h72;
			default: m = 8'h6B;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== sv/midi_track_event_parser_unit.sv =====
// path: an input transaction reaches the earliest result transaction through the input register
// and then the result register; throughput: one byte per cycle while the output is not stalled,
// and each byte updates the parser state in one combinational pass
// a byte that gives no result produces no output transaction
// reset: asynchronous active low, clears the parser state and both valid flags,
// the parser then ignores bytes until one with track_start set
`default_nettype none
`include "midi_track_event_parser_unit_defines.svh"

module midi_track_event_parser_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // data_byte
	input  wire logic        s_axis_tuser,  // track_start
	input  wire logic        s_axis_tlast,  // stream_last
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [79:0]      m_axis_tdata,  // event_tick, status_byte, first_data, second_data,
	                                        // tempo_us, zero pad
	output logic [1:0]       m_axis_tuser   // kind
);

	localparam int TB = mtep_pkg::TICK_BITS;
	localparam int VB = mtep_pkg::VLV_BITS;
	localparam int LB = mtep_pkg::LEN_BITS;

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              start_s1;
	logic              last_s1;
	logic              adv;

	mtep_pkg::phase_t  phase_q, phase_d;
	logic [2:0]        hdr_q, hdr_d;
	logic [LB-1:0]     left_q, left_d;
	logic [TB-1:0]     tick_q, tick_d;
	logic [7:0]        rs_q, rs_d;
	logic [VB-1:0]     vlv_q, vlv_d;
	logic [2:0]        cnt_q, cnt_d;
	logic [7:0]        meta_q, meta_d;
	logic [VB-1:0]     skip_q, skip_d;
	logic [7:0]        held_q, held_d;
	logic [23:0]       tempo_q, tempo_d;
	logic              ended_q, ended_d;

	logic              res;
	mtep_pkg::kind_t   r_kind;
	logic [TB-1:0]     r_tick;
	logic [7:0]        r_status, r_d1, r_d2;
	logic [23:0]       r_tempo;

	logic              out_valid_q;
	logic [1:0]        out_kind_q;
	logic [79:0]       out_data_q;

	assign adv = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tuser = out_kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
			last_s1 <= s_axis_tlast;
		end
	end

	always_comb begin
		logic [VB-1:0]   vlv_new;
		logic [2:0]      cnt_new;
		logic            vlv_bad;
		logic [TB:0]     tick_sum;
		logic            err;
		logic            ch_one;
		logic [7:0]      rs_use;

		phase_d = phase_q;
		hdr_d = hdr_q;
		left_d = left_q;
		tick_d = tick_q;
		rs_d = rs_q;
		vlv_d = vlv_q;
		cnt_d = cnt_q;
		meta_d = meta_q;
		skip_d = skip_q;
		held_d = held_q;
		tempo_d = tempo_q;
		ended_d = ended_q;
		err = 1'b0;
		res = 1'b0;
		r_kind = mtep_pkg::KIND_CHAN;
		r_tick = '0;
		r_status = '0;
		r_d1 = '0;
		r_d2 = '0;
		r_tempo = '0;

		if (start_s1) begin
			tick_d = '0;
			rs_d = '0;
			hdr_d = '0;
			left_d = '0;
			ended_d = 1'b0;
			vlv_d = '0;
			cnt_d = '0;
			phase_d = mtep_pkg::PH_HDR;
		end

		vlv_new = {vlv_d[VB-8:0], byte_s1[6:0]};
		cnt_new = cnt_d + 3'd1;
		vlv_bad = byte_s1[7] && (cnt_new >= mtep_pkg::VLV_MAX_BYTES);
		tick_sum = {1'b0, vlv_new[TB-1:0]} + {1'b0, tick_d};
		ch_one = (rs_d[7:4] == 4'hC) || (rs_d[7:4] == 4'hD);
		rs_use = rs_d;

		if (phase_d != mtep_pkg::PH_IDLE) begin
			if (phase_d == mtep_pkg::PH_HDR) begin
				if (!hdr_d[2]) begin
					if (byte_s1 != mtep_pkg::magic_byte(hdr_d[1:0])) begin
						err = 1'b1;
					end
				end else begin
					left_d = {left_d[LB-9:0], byte_s1};
				end
				hdr_d = hdr_d + 3'd1;
				if (!err && hdr_d == 3'd0) begin
					phase_d = mtep_pkg::PH_DELTA;
					vlv_d = '0;
					cnt_d = '0;
				end
			end else begin
				if (left_d != '0) begin
					left_d = left_d - LB'(1);
				end
				case (phase_d)
					mtep_pkg::PH_DELTA: begin
						vlv_d = vlv_new;
						cnt_d = cnt_new;
						if (vlv_bad) begin
							err = 1'b1;
						end else if (!byte_s1[7]) begin
							if ((VB > TB && vlv_new > VB'(mtep_pkg::TICK_MAX))
									|| tick_sum > mtep_pkg::TICK_MAX) begin
								err = 1'b1;
							end else begin
								tick_d = tick_sum[TB-1:0];
								phase_d = mtep_pkg::PH_EVENT;
							end
						end
					end
					mtep_pkg::PH_EVENT, mtep_pkg::PH_DATA1: begin
						if (phase_d == mtep_pkg::PH_EVENT && byte_s1 == mtep_pkg::META_PREFIX) begin
							phase_d = mtep_pkg::PH_MTYPE;
						end else if (phase_d == mtep_pkg::PH_EVENT &&
								(byte_s1 == mtep_pkg::SYSEX_START ||
								byte_s1 == mtep_pkg::SYSEX_ESC)) begin
							phase_d = mtep_pkg::PH_SLEN;
							vlv_d = '0;
							cnt_d = '0;
						end else if (phase_d == mtep_pkg::PH_EVENT && byte_s1[7]) begin
							rs_d = byte_s1;
							phase_d = mtep_pkg::PH_DATA1;
						end else if (phase_d == mtep_pkg::PH_EVENT && rs_use == 8'h00) begin
							err = 1'b1;
						end else if (ch_one) begin
							res = 1'b1;
							r_kind = mtep_pkg::KIND_CHAN;
							r_tick = tick_d;
							r_status = rs_use;
							r_d1 = byte_s1;
							phase_d = mtep_pkg::PH_DELTA;
							vlv_d = '0;
							cnt_d = '0;
						end else begin
							held_d = byte_s1;
							phase_d = mtep_pkg::PH_DATA2;
						end
					end
					mtep_pkg::PH_DATA2: begin
						res = 1'b1;
						r_kind = mtep_pkg::KIND_CHAN;
						r_tick = tick_d;
						r_status = rs_d;
						r_d1 = held_d;
						r_d2 = byte_s1;
						phase_d = mtep_pkg::PH_DELTA;
						vlv_d = '0;
						cnt_d = '0;
					end
					mtep_pkg::PH_MTYPE: begin
						meta_d = byte_s1;
						phase_d = mtep_pkg::PH_MLEN;
						vlv_d = '0;
						cnt_d = '0;
					end
					mtep_pkg::PH_MLEN, mtep_pkg::PH_SLEN: begin
						vlv_d = vlv_new;
						cnt_d = cnt_new;
						if (vlv_bad) begin
							err = 1'b1;
						end else if (!byte_s1[7]) begin
							if (LB'(vlv_new) > left_d) begin
								err = 1'b1;
							end else if (phase_d == mtep_pkg::PH_MLEN &&
									meta_d == mtep_pkg::META_EOT) begin
								ended_d = 1'b1;
								phase_d = mtep_pkg::PH_TAIL;
							end else begin
								if (phase_d == mtep_pkg::PH_SLEN ||
										(meta_d == mtep_pkg::META_TEMPO &&
										vlv_new != mtep_pkg::TEMPO_LEN)) begin
									meta_d = '0;
								end
								if (vlv_new == '0) begin
									phase_d = mtep_pkg::PH_DELTA;
									vlv_d = '0;
									cnt_d = '0;
								end else begin
									skip_d = vlv_new;
									tempo_d = '0;
									phase_d = mtep_pkg::PH_SKIP;
								end
							end
						end
					end
					mtep_pkg::PH_SKIP: begin
						tempo_d = {tempo_d[15:0], byte_s1};
						if (skip_d != '0) begin
							skip_d = skip_d - VB'(1);
						end
						if (skip_d == '0) begin
							if (meta_d == mtep_pkg::META_TEMPO) begin
								res = 1'b1;
								r_kind = mtep_pkg::KIND_TEMPO;
								r_tick = tick_d;
								r_tempo = tempo_d;
							end
							phase_d = mtep_pkg::PH_DELTA;
							vlv_d = '0;
							cnt_d = '0;
						end
					end
					default: begin
					end
				endcase
			end

			if (!err && phase_d != mtep_pkg::PH_HDR && left_d == '0) begin
				if (ended_d || (phase_d == mtep_pkg::PH_DELTA && cnt_d == 3'd0)) begin
					if (!res) begin
						res = 1'b1;
						r_kind = mtep_pkg::KIND_DONE;
						r_tick = tick_d;
						r_status = '0;
						r_d1 = '0;
						r_d2 = '0;
						r_tempo = '0;
					end
					phase_d = mtep_pkg::PH_IDLE;
				end else begin
					err = 1'b1;
				end
			end
			if (!err && last_s1 && phase_d != mtep_pkg::PH_IDLE) begin
				err = 1'b1;
			end
			if (err) begin
				res = 1'b1;
				r_kind = mtep_pkg::KIND_ERROR;
				r_tick = '0;
				r_status = '0;
				r_d1 = '0;
				r_d2 = '0;
				r_tempo = '0;
				phase_d = mtep_pkg::PH_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mtep_pkg::PH_IDLE;
			hdr_q <= '0;
			left_q <= '0;
			tick_q <= '0;
			rs_q <= '0;
			vlv_q <= '0;
			cnt_q <= '0;
			meta_q <= '0;
			skip_q <= '0;
			held_q <= '0;
			tempo_q <= '0;
			ended_q <= 1'b0;
		end else if (valid_s1 && adv) begin
			phase_q <= phase_d;
			hdr_q <= hdr_d;
			left_q <= left_d;
			tick_q <= tick_d;
			rs_q <= rs_d;
			vlv_q <= vlv_d;
			cnt_q <= cnt_d;
			meta_q <= meta_d;
			skip_q <= skip_d;
			held_q <= held_d;
			tempo_q <= tempo_d;
			ended_q <= ended_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1 && res;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && res) begin
			out_kind_q <= r_kind;
			out_data_q <= {4'b0, r_tempo, r_d2, r_d1, r_status, 28'(r_tick)};
		end
	end

	`MTEP_ASSERT_NOW(a_err_payload_zero,
		out_valid_q && out_kind_q == mtep_pkg::KIND_ERROR, out_data_q == '0)
	`MTEP_ASSERT_NEXT(a_idle_no_result,
		valid_s1 && adv && phase_q == mtep_pkg::PH_IDLE && !start_s1, !m_axis_tvalid)
	`MTEP_ASSERT_NOW(a_status_has_msb, rs_q != 8'h00, rs_q[7])
	`MTEP_ASSERT_NOW(a_body_bytes_left,
		phase_q != mtep_pkg::PH_IDLE && phase_q != mtep_pkg::PH_HDR, left_q != '0)

endmodule

`default_nettype wire
